FILE: hw/rtl/tsm_pkg.sv
// Package for the tire sensor monitor: slot count, field widths, mode,
// status and register codes, controller states and the command/status structs.
// Depends on nothing; every other file of the block imports it.
package tsm_pkg;

    localparam int NUM_SLOTS = 6;
    localparam int MAX_OUT   = 6;
    localparam int NUM_OUT   = (NUM_SLOTS < MAX_OUT) ? NUM_SLOTS : MAX_OUT;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Warning band of 5 units and cold limit of 33 degrees, both in 1/16.
    localparam logic signed [13:0] BAND       = 14'sd80;
    localparam logic signed [13:0] COLD_LIMIT = 14'sd528;

    typedef enum logic [1:0] {
        MODE_PACKET = 2'd0,
        MODE_CHECK  = 2'd1,
        MODE_PAIR   = 2'd2,
        MODE_RADIO  = 2'd3
    } mode_t;

    localparam logic [1:0] SLOT_FRESH    = 2'd0;
    localparam logic [1:0] SLOT_STALE    = 2'd1;
    localparam logic [1:0] SLOT_NODATA   = 2'd2;
    localparam logic [1:0] SLOT_TIMEDOUT = 2'd3;
    localparam logic [2:0] STATUS_UNPAIRED = 3'd4;

    localparam logic [1:0] PLEVEL_OK   = 2'd0;
    localparam logic [1:0] PLEVEL_WARN = 2'd1;
    localparam logic [1:0] PLEVEL_ALARM = 2'd2;

    localparam logic [1:0] TLEVEL_COLD   = 2'd0;
    localparam logic [1:0] TLEVEL_NORMAL = 2'd1;
    localparam logic [1:0] TLEVEL_WARN   = 2'd2;
    localparam logic [1:0] TLEVEL_ALARM  = 2'd3;

    localparam logic [2:0] CFG_PRESSURE_MIN = 3'd0;
    localparam logic [2:0] CFG_PRESSURE_MAX = 3'd1;
    localparam logic [2:0] CFG_TEMP_MAX     = 3'd2;
    localparam logic [2:0] CFG_TIMEOUT      = 3'd3;
    localparam logic [2:0] CFG_RADIO_RESET  = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_START  = 2'd1,
        S_SCAN   = 2'd2,
        S_REPORT = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic latch_in;
        logic idx_clr;
        logic idx_inc;
        logic idx_load_sel;
        logic write_packet;
        logic write_pair;
        logic age;
        logic radio;
        logic load_out;
        logic out_last;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  id_zero;
        logic  sel_bad;
        logic  match;
        logic  idx_last_slot;
        logic  idx_last_rep;
        logic  out_free;
    } dp_status_t;

endpackage

FILE: hw/rtl/tsm_ctrl.sv
// Controller of the tire sensor monitor: sequences the slot walk for each item.
// Depends on tsm_pkg; drives the datapath through dp_cmd_t.
module tsm_ctrl
    import tsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        rep_last;

    // A check item reports every slot; a packet or pair item reports at most one slot.
    assign rep_last = (status.mode == MODE_CHECK) ? status.idx_last_rep : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                case (status.mode)
                    MODE_PACKET: state_next = status.id_zero ? S_IDLE : S_SCAN;
                    MODE_PAIR:   state_next = status.sel_bad ? S_IDLE : S_REPORT;
                    default:     state_next = S_SCAN;
                endcase
            end
            S_SCAN:
            begin
                case (status.mode)
                    MODE_PACKET:
                    begin
                        if (status.match)
                        begin
                            state_next = S_REPORT;
                        end
                        else if (status.idx_last_slot)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    MODE_CHECK:
                    begin
                        if (status.idx_last_slot)
                        begin
                            state_next = S_REPORT;
                        end
                    end
                    MODE_RADIO:
                    begin
                        if (status.idx_last_slot)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_REPORT:
            begin
                if (status.out_free && rep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.latch_in = in_valid;
            end
            S_START:
            begin
                cmd.idx_clr = 1'b1;
                if (status.mode == MODE_PAIR)
                begin
                    cmd.idx_clr      = 1'b0;
                    cmd.idx_load_sel = 1'b1;
                    cmd.write_pair   = !status.sel_bad;
                end
            end
            S_SCAN:
            begin
                case (status.mode)
                    MODE_PACKET:
                    begin
                        cmd.write_packet = status.match;
                        cmd.idx_inc      = !status.match;
                    end
                    MODE_CHECK:
                    begin
                        cmd.age     = 1'b1;
                        cmd.idx_clr = status.idx_last_slot;
                        cmd.idx_inc = !status.idx_last_slot;
                    end
                    MODE_RADIO:
                    begin
                        cmd.radio   = 1'b1;
                        cmd.idx_inc = !status.idx_last_slot;
                    end
                    default: cmd = '0;
                endcase
            end
            S_REPORT:
            begin
                cmd.load_out = status.out_free;
                cmd.out_last = rep_last;
                cmd.idx_inc  = status.out_free && !rep_last;
            end
            default: cmd = '0;
        endcase
    end

endmodule

FILE: hw/rtl/tsm_datapath.sv
// Datapath of the tire sensor monitor: configuration, input latch, slot table,
// slot index, level evaluation and output register. Depends on tsm_pkg.
module tsm_datapath
    import tsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic [1:0]         mode,
    input  logic [31:0]        sensor_id,
    input  logic [2:0]         slot_sel,
    input  logic [11:0]        pressure_in,
    input  logic signed [11:0] temp_in,
    input  logic [31:0]        now_ms,
    input  logic               moving,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         slot_out,
    output logic [2:0]         slot_status,
    output logic [11:0]        pressure_out,
    output logic signed [11:0] temp_out,
    output logic [1:0]         pressure_level,
    output logic [1:0]         temp_level,
    output logic               last
);

    logic [11:0] pmin_reg;
    logic [11:0] pmax_reg;
    logic [11:0] tmax_reg;
    logic [31:0] timeout_reg;
    logic [31:0] radio_reg;

    mode_t       mode_reg;
    logic [31:0] id_reg;
    logic [2:0]  sel_reg;
    logic [11:0] p_reg;
    logic [11:0] t_reg;
    logic [31:0] now_reg;
    logic        moving_reg;

    logic [31:0] sid_reg   [NUM_SLOTS];
    logic [1:0]  sst_reg   [NUM_SLOTS];
    logic [11:0] sp_reg    [NUM_SLOTS];
    logic [11:0] st_reg    [NUM_SLOTS];
    logic [31:0] stamp_reg [NUM_SLOTS];
    logic [31:0] sid_next   [NUM_SLOTS];
    logic [1:0]  sst_next   [NUM_SLOTS];
    logic [11:0] sp_next    [NUM_SLOTS];
    logic [11:0] st_next    [NUM_SLOTS];
    logic [31:0] stamp_next [NUM_SLOTS];

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] sel_idx;
    logic [4:0]       sel_wide;
    logic [4:0]       idx_wide;

    logic [31:0] cur_id;
    logic [1:0]  cur_st;
    logic [11:0] cur_p;
    logic [11:0] cur_t;
    logic [31:0] cur_stamp;
    logic [31:0] age_ms;
    logic        cur_fresh;

    logic [2:0]         rep_status;
    logic signed [13:0] p14;
    logic signed [13:0] pmin14;
    logic signed [13:0] pmax14;
    logic signed [13:0] t14;
    logic signed [13:0] tmax14;
    logic [1:0]         pl;
    logic [1:0]         tl;

    logic               out_valid_reg;
    logic [2:0]         slot_out_reg;
    logic [2:0]         status_out_reg;
    logic [11:0]        p_out_reg;
    logic [11:0]        t_out_reg;
    logic [1:0]         pl_reg;
    logic [1:0]         tl_reg;
    logic               last_reg;

    // Configuration registers; writes should come only while the block is idle, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmin_reg    <= 12'd1120;
            pmax_reg    <= 12'd1760;
            tmax_reg    <= 12'd1120;
            timeout_reg <= 32'd600000;
            radio_reg   <= 32'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PRESSURE_MIN: pmin_reg    <= cfg_data[11:0];
                CFG_PRESSURE_MAX: pmax_reg    <= cfg_data[11:0];
                CFG_TEMP_MAX:     tmax_reg    <= cfg_data[11:0];
                CFG_TIMEOUT:      timeout_reg <= cfg_data;
                CFG_RADIO_RESET:  radio_reg   <= cfg_data;
                default:          pmin_reg    <= pmin_reg;
            endcase
        end
    end

    // Input item latch.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            mode_reg   <= mode_t'(mode);
            id_reg     <= sensor_id;
            sel_reg    <= slot_sel;
            p_reg      <= pressure_in;
            t_reg      <= temp_in;
            now_reg    <= now_ms;
            moving_reg <= moving;
        end
    end

    assign sel_wide = {2'b00, sel_reg};
    assign sel_idx  = sel_wide[IDX_W-1:0];

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_load_sel)
        begin
            idx_next = sel_idx;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    assign cur_id    = sid_reg[idx_reg];
    assign cur_st    = sst_reg[idx_reg];
    assign cur_p     = sp_reg[idx_reg];
    assign cur_t     = st_reg[idx_reg];
    assign cur_stamp = stamp_reg[idx_reg];
    assign age_ms    = now_reg - cur_stamp;
    assign cur_fresh = (cur_id != 32'd0) && (cur_st == SLOT_FRESH);

    // Slot table update, one slot per cycle at the walk index, or at the selected slot for a pair write.
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            sid_next[i]   = sid_reg[i];
            sst_next[i]   = sst_reg[i];
            sp_next[i]    = sp_reg[i];
            st_next[i]    = st_reg[i];
            stamp_next[i] = stamp_reg[i];
        end
        if (cmd.write_pair)
        begin
            sid_next[sel_idx]   = id_reg;
            sst_next[sel_idx]   = SLOT_NODATA;
            stamp_next[sel_idx] = 32'd0;
        end
        if (cmd.write_packet)
        begin
            sp_next[idx_reg]    = p_reg;
            st_next[idx_reg]    = t_reg;
            stamp_next[idx_reg] = now_reg;
            sst_next[idx_reg]   = SLOT_FRESH;
        end
        if (cmd.age && cur_fresh && (age_ms > timeout_reg))
        begin
            sst_next[idx_reg] = moving_reg ? SLOT_TIMEDOUT : SLOT_STALE;
        end
        if (cmd.radio && cur_fresh)
        begin
            stamp_next[idx_reg] = cur_stamp - radio_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                sid_reg[i]   <= '0;
                sst_reg[i]   <= SLOT_NODATA;
                sp_reg[i]    <= '0;
                st_reg[i]    <= '0;
                stamp_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                sid_reg[i]   <= sid_next[i];
                sst_reg[i]   <= sst_next[i];
                sp_reg[i]    <= sp_next[i];
                st_reg[i]    <= st_next[i];
                stamp_reg[i] <= stamp_next[i];
            end
        end
    end

    // Status and warning levels for the slot at the walk index.
    assign rep_status = (cur_id != 32'd0) ? {1'b0, cur_st} : STATUS_UNPAIRED;
    assign p14    = signed'({2'b00, cur_p});
    assign pmin14 = signed'({2'b00, pmin_reg});
    assign pmax14 = signed'({2'b00, pmax_reg});
    assign t14    = signed'({{2{cur_t[11]}}, cur_t});
    assign tmax14 = signed'({{2{tmax_reg[11]}}, tmax_reg});

    always_comb
    begin
        pl = PLEVEL_OK;
        tl = TLEVEL_COLD;
        if (rep_status == {1'b0, SLOT_FRESH})
        begin
            if (p14 > 14'sd0)
            begin
                if ((p14 <= pmin14) || (p14 >= pmax14))
                begin
                    pl = PLEVEL_ALARM;
                end
                else if ((p14 <= pmin14 + BAND) || (p14 >= pmax14 - BAND))
                begin
                    pl = PLEVEL_WARN;
                end
            end
            if ((t14 > 14'sd0) && (t14 >= tmax14))
            begin
                tl = TLEVEL_ALARM;
            end
            else if ((t14 > 14'sd0) && (t14 >= tmax14 - BAND))
            begin
                tl = TLEVEL_WARN;
            end
            else if (t14 < COLD_LIMIT)
            begin
                tl = TLEVEL_COLD;
            end
            else
            begin
                tl = TLEVEL_NORMAL;
            end
        end
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign idx_wide = 5'(idx_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            slot_out_reg   <= idx_wide[2:0];
            status_out_reg <= rep_status;
            p_out_reg      <= (cur_id != 32'd0) ? cur_p : 12'd0;
            t_out_reg      <= (cur_id != 32'd0) ? cur_t : 12'd0;
            pl_reg         <= pl;
            tl_reg         <= tl;
            last_reg       <= cmd.out_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign slot_out       = slot_out_reg;
    assign slot_status    = status_out_reg;
    assign pressure_out   = p_out_reg;
    assign temp_out       = signed'(t_out_reg);
    assign pressure_level = pl_reg;
    assign temp_level     = tl_reg;
    assign last           = last_reg;

    assign status.mode          = mode_reg;
    assign status.id_zero       = (id_reg == 32'd0);
    assign status.sel_bad       = (sel_wide >= 5'(NUM_SLOTS));
    assign status.match         = (cur_id == id_reg);
    assign status.idx_last_slot = (idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign status.idx_last_rep  = (idx_reg == IDX_W'(NUM_OUT - 1));
    assign status.out_free      = !out_valid_reg || !out_stall;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("pending result overwritten");

    a_unpaired_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_out_reg == STATUS_UNPAIRED))
        |-> ((p_out_reg == 12'd0) && (t_out_reg == 12'd0)))
        else $error("unpaired slot reports a reading");

    a_level_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((pl_reg != PLEVEL_OK) || (tl_reg != TLEVEL_COLD)))
        |-> (status_out_reg == {1'b0, SLOT_FRESH}))
        else $error("level reported for a slot that is not fresh");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write_pair && (cmd.write_packet || cmd.age || cmd.radio)))
        else $error("pair write overlaps a slot walk");
`endif

endmodule

FILE: hw/rtl/tire_sensor_monitor.sv
// Top level of the tire sensor monitor: joins the controller and the datapath.
// Depends on tsm_pkg, tsm_ctrl and tsm_datapath.
//
// Usage. Items arrive on the input channel (in_valid, in_stall and the item
// fields); a transfer takes place at a rising edge with in_valid high and
// in_stall low. Results leave on the output channel (out_valid, out_stall and
// the result fields), one transfer per result, with last set on the final
// result of an item. Registers are written through cfg_valid, cfg_index and
// cfg_data; cfg_ready is always high, so each valid cycle is one transfer,
// and writes should be made only while no item is in progress.
// The block handles one item at a time, walking the slot table one slot per
// cycle. A pair item with a valid slot has a start state and a report state; a
// packet walks up from slot 0 until its ID matches, then reports (none for ID
// zero or no match); a timeout check has a start state, walks every slot, then
// reports one slot at a time; a radio reset has a start state and walks every
// slot without a report. The next item is taken as soon as the walk returns to
// idle, even while the last result still waits in the output register. Reset
// clears all slots to unpaired with no data and restores the register
// defaults. When the receiver stalls, the result is held and the walk waits.
module tire_sensor_monitor
    import tsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [31:0]        sensor_id,
    input  logic [2:0]         slot_sel,
    input  logic [11:0]        pressure_in,
    input  logic signed [11:0] temp_in,
    input  logic [31:0]        now_ms,
    input  logic               moving,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         slot_out,
    output logic [2:0]         slot_status,
    output logic [11:0]        pressure_out,
    output logic signed [11:0] temp_out,
    output logic [1:0]         pressure_level,
    output logic [1:0]         temp_level,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Register writes are always accepted.
    assign cfg_ready = 1'b1;

    tsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tsm_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mode           (mode),
        .sensor_id      (sensor_id),
        .slot_sel       (slot_sel),
        .pressure_in    (pressure_in),
        .temp_in        (temp_in),
        .now_ms         (now_ms),
        .moving         (moving),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .slot_out       (slot_out),
        .slot_status    (slot_status),
        .pressure_out   (pressure_out),
        .temp_out       (temp_out),
        .pressure_level (pressure_level),
        .temp_level     (temp_level),
        .last           (last)
    );

endmodule

FILE: test/tb.sv
// Self-checking bench for the tyre sensor monitor: directed corner items, then random
// traffic under four register settings, with idle and stall patterns on both channels.
// Depends on tsm_pkg and tire_sensor_monitor only.
module tb
    import tsm_pkg::*;
;

    // Run limits. The drain wait covers the longest walk that gives no result,
    // a radio reset, with room to spare.
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 300000;
    localparam int ITEMS_PER_PHASE = 47;

    typedef enum {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    // One input item, field for field as it sits on the ports.
    typedef struct packed {
        mode_t       mode;
        logic [31:0] sensor_id;
        logic [2:0]  slot_sel;
        logic [11:0] pressure_in;
        logic [11:0] temp_in;
        logic [31:0] now_ms;
        logic        moving;
    } tyre_item_t;

    // One slot reading as the block reports it.
    typedef struct packed {
        logic [2:0]  slot;
        logic [2:0]  status;
        logic [11:0] pressure;
        logic [11:0] temp;
        logic [1:0]  pressure_level;
        logic [1:0]  temp_level;
        logic        last;
    } slot_reading_t;

    // The scoreboard keeps its own copy of the slot table and the registers.
    // Every accepted item is applied to that copy, and the readings it should
    // cause are queued in order; every reading from the block is checked
    // against the oldest one in the queue.
    class tyre_table_scoreboard;
        logic [31:0] pair_id [NUM_SLOTS];
        logic [1:0]  state   [NUM_SLOTS];
        logic [11:0] pres    [NUM_SLOTS];
        logic [11:0] temp    [NUM_SLOTS];
        logic [31:0] stamp   [NUM_SLOTS];
        logic [11:0] pressure_lo;
        logic [11:0] pressure_hi;
        logic [11:0] temp_hi;
        logic [31:0] timeout;
        logic [31:0] radio_step;
        slot_reading_t due_readings[$];
        int mismatches;
        int readings_seen;
        int items_seen;

        function new();
            pressure_lo = 12'd1120;
            pressure_hi = 12'd1760;
            temp_hi     = 12'd1120;
            timeout     = 32'd600000;
            radio_step  = 32'd0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                pair_id[i] = '0;
                state[i]   = SLOT_NODATA;
                pres[i]    = '0;
                temp[i]    = '0;
                stamp[i]   = '0;
            end
            mismatches    = 0;
            readings_seen = 0;
            items_seen    = 0;
        endfunction

        function void set_reg(logic [2:0] index, logic [31:0] value);
            case (index)
                CFG_PRESSURE_MIN: pressure_lo = value[11:0];
                CFG_PRESSURE_MAX: pressure_hi = value[11:0];
                CFG_TEMP_MAX:     temp_hi     = value[11:0];
                CFG_TIMEOUT:      timeout     = value;
                CFG_RADIO_RESET:  radio_step  = value;
                default: ;
            endcase
        endfunction

        // Levels are judged on signed values; the warning band lies inside
        // each alarm limit and only a fresh slot carries levels at all.
        function slot_reading_t reading_of(int s, bit fin);
            slot_reading_t r;
            int p;
            int t;
            int lo;
            int hi;
            int tm;
            int band;
            int cold;
            p    = int'(pres[s]);
            t    = int'($signed(temp[s]));
            lo   = int'(pressure_lo);
            hi   = int'(pressure_hi);
            tm   = int'($signed(temp_hi));
            band = int'(BAND);
            cold = int'(COLD_LIMIT);
            r.slot           = 3'(s);
            r.status         = (pair_id[s] != 0) ? {1'b0, state[s]} : STATUS_UNPAIRED;
            r.pressure       = (pair_id[s] != 0) ? pres[s] : 12'd0;
            r.temp           = (pair_id[s] != 0) ? temp[s] : 12'd0;
            r.pressure_level = PLEVEL_OK;
            r.temp_level     = TLEVEL_COLD;
            r.last           = fin;
            if (r.status == {1'b0, SLOT_FRESH})
            begin
                if (p > 0)
                begin
                    if (p <= lo || p >= hi)
                        r.pressure_level = PLEVEL_ALARM;
                    else if (p <= lo + band || p >= hi - band)
                        r.pressure_level = PLEVEL_WARN;
                end
                if (t > 0 && t >= tm)
                    r.temp_level = TLEVEL_ALARM;
                else if (t > 0 && t >= tm - band)
                    r.temp_level = TLEVEL_WARN;
                else if (t < cold)
                    r.temp_level = TLEVEL_COLD;
                else
                    r.temp_level = TLEVEL_NORMAL;
            end
            return r;
        endfunction

        function void note_item(tyre_item_t it);
            bit found;
            found = 1'b0;
            items_seen++;
            case (it.mode)
                MODE_PACKET:
                    if (it.sensor_id != 0)
                        for (int i = 0; i < NUM_SLOTS; i++)
                            if (!found && pair_id[i] == it.sensor_id)
                            begin
                                found    = 1'b1;
                                pres[i]  = it.pressure_in;
                                temp[i]  = it.temp_in;
                                stamp[i] = it.now_ms;
                                state[i] = SLOT_FRESH;
                                due_readings.push_back(reading_of(i, 1'b1));
                            end
                MODE_CHECK:
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (pair_id[i] != 0 && state[i] == SLOT_FRESH &&
                            (it.now_ms - stamp[i]) > timeout)
                            state[i] = it.moving ? SLOT_TIMEDOUT : SLOT_STALE;
                    for (int i = 0; i < NUM_OUT; i++)
                        due_readings.push_back(reading_of(i, i == NUM_OUT - 1));
                end
                MODE_PAIR:
                    if (it.slot_sel < NUM_SLOTS)
                    begin
                        pair_id[it.slot_sel] = it.sensor_id;
                        state[it.slot_sel]   = SLOT_NODATA;
                        stamp[it.slot_sel]   = '0;
                        due_readings.push_back(reading_of(it.slot_sel, 1'b1));
                    end
                default:
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (pair_id[i] != 0 && state[i] == SLOT_FRESH)
                            stamp[i] = stamp[i] - radio_step;
            endcase
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t, reading %0d: %s", $time, readings_seen, what);
            mismatches++;
        endtask

        task check_field(string name, logic [11:0] got, logic [11:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        endtask

        task check_reading(slot_reading_t got);
            slot_reading_t want;
            readings_seen++;
            if (due_readings.size() == 0)
                report_mismatch("reading arrived with none outstanding");
            else
            begin
                want = due_readings.pop_front();
                check_field("slot_out", 12'(got.slot), 12'(want.slot));
                check_field("slot_status", 12'(got.status), 12'(want.status));
                check_field("pressure_out", got.pressure, want.pressure);
                check_field("temp_out", got.temp, want.temp);
                check_field("pressure_level", 12'(got.pressure_level),
                            12'(want.pressure_level));
                check_field("temp_level", 12'(got.temp_level), 12'(want.temp_level));
                check_field("last", 12'(got.last), 12'(want.last));
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         mode = '0;
    logic [31:0]        sensor_id = '0;
    logic [2:0]         slot_sel = '0;
    logic [11:0]        pressure_in = '0;
    logic signed [11:0] temp_in = '0;
    logic [31:0]        now_ms = '0;
    logic               moving = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         slot_out;
    logic [2:0]         slot_status;
    logic [11:0]        pressure_out;
    logic signed [11:0] temp_out;
    logic [1:0]         pressure_level;
    logic [1:0]         temp_level;
    logic               last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    tyre_table_scoreboard sb = new();
    idle_mode_t idle_mode = IDLE_NONE;
    logic [31:0] id_pool [NUM_SLOTS];
    logic [31:0] clock_ms = '0;
    int cycle_count = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;

    tire_sensor_monitor u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .sensor_id      (sensor_id),
        .slot_sel       (slot_sel),
        .pressure_in    (pressure_in),
        .temp_in        (temp_in),
        .now_ms         (now_ms),
        .moving         (moving),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .slot_out       (slot_out),
        .slot_status    (slot_status),
        .pressure_out   (pressure_out),
        .temp_out       (temp_out),
        .pressure_level (pressure_level),
        .temp_level     (temp_level),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Per-cycle idle chances, in percent, for the current phase.
    function int source_pct();
        return (idle_mode == IDLE_SOURCE) ? 59 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    endfunction

    function int sink_pct();
        return (idle_mode == IDLE_SINK) ? 59 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    endfunction

    // Receiver side. A hold-off request from the main sequence makes this
    // process keep out_stall high for a long stretch, counted here, while the
    // sender carries on offering items so that the block backs up and stalls
    // its input. Otherwise the stall follows the idle pattern of the phase.
    always @(posedge clk)
    begin
        if (hold_left == 0 && hold_seen != hold_asks)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < sink_pct());
    end

    // Every reading transfer is checked as it happens; the values sampled here
    // are those held before the edge, so no ordering within the step matters.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_reading({slot_out, slot_status, pressure_out, temp_out,
                              pressure_level, temp_level, last});
    end

    // Offers one item and returns at the edge where it is transferred. Valid
    // stays high after the transfer; it is lowered only when a gap follows or
    // the stream ends, so it never gets two assignments in one step.
    task send_item(tyre_item_t it);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < source_pct())
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= it.mode;
        sensor_id   <= it.sensor_id;
        slot_sel    <= it.slot_sel;
        pressure_in <= it.pressure_in;
        temp_in     <= it.temp_in;
        now_ms      <= it.now_ms;
        moving      <= it.moving;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(it);
    endtask

    task write_reg(logic [2:0] index, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(index, value);
    endtask

    task configure(logic [11:0] lo, logic [11:0] hi, logic [11:0] tm,
                   logic [31:0] tmo, logic [31:0] step);
        write_reg(CFG_PRESSURE_MIN, {20'd0, lo});
        write_reg(CFG_PRESSURE_MAX, {20'd0, hi});
        write_reg(CFG_TEMP_MAX, {20'd0, tm});
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_RADIO_RESET, step);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every outstanding reading has come back, then lets a radio
    // reset walk, which gives no reading, finish as well.
    task drain();
        while (sb.due_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function tyre_item_t make_item(mode_t m, logic [31:0] id, logic [2:0] sel,
                                   logic [11:0] p, logic [11:0] t, logic [31:0] now,
                                   logic mv);
        tyre_item_t it;
        it.mode        = m;
        it.sensor_id   = id;
        it.slot_sel    = sel;
        it.pressure_in = p;
        it.temp_in     = t;
        it.now_ms      = now;
        it.moving      = mv;
        return it;
    endfunction

    function logic [11:0] near(logic [11:0] centre);
        return centre + 12'($urandom_range(0, 200)) - 12'd100;
    endfunction

    function void refresh_pool();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            id_pool[i] = $urandom;
            if (id_pool[i] == 0)
                id_pool[i] = 32'd1;
        end
    endfunction

    // Mostly well-formed traffic: pairing with IDs from a small pool, packets
    // from those sensors on an advancing clock with readings near the limits,
    // checks shortly after, radio resets; the rest is unmatched or junk.
    function tyre_item_t random_item();
        tyre_item_t it;
        int pick;
        clock_ms       = clock_ms + $urandom_range(0, 400);
        it.mode        = MODE_PACKET;
        it.sensor_id   = id_pool[$urandom_range(0, NUM_SLOTS - 1)];
        it.slot_sel    = 3'($urandom_range(0, 7));
        it.pressure_in = 12'($urandom);
        it.temp_in     = 12'($urandom);
        it.now_ms      = clock_ms;
        it.moving      = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            case ($urandom_range(0, 9))
                0: it.sensor_id = '0;
                1: it.sensor_id = $urandom;
                default: ;
            endcase
            case ($urandom_range(0, 4))
                0: it.pressure_in = near(sb.pressure_lo);
                1: it.pressure_in = near(sb.pressure_hi);
                2: it.pressure_in = '0;
                default: ;
            endcase
            case ($urandom_range(0, 4))
                0: it.temp_in = near(sb.temp_hi);
                1: it.temp_in = near(12'(COLD_LIMIT));
                2: it.temp_in = 12'($urandom_range(0, 16)) - 12'd8;
                default: ;
            endcase
        end
        else if (pick < 60)
        begin
            it.mode   = MODE_CHECK;
            it.now_ms = ($urandom_range(0, 9) == 0) ? $urandom
                                                    : clock_ms + $urandom_range(0, 3000);
        end
        else if (pick < 80)
        begin
            it.mode = MODE_PAIR;
            case ($urandom_range(0, 9))
                0: it.sensor_id = '0;
                1: it.sensor_id = $urandom;
                default: ;
            endcase
        end
        else if (pick < 90)
            it.mode = MODE_RADIO;
        else
        begin
            it.mode      = mode_t'($urandom_range(0, 3));
            it.sensor_id = $urandom;
            it.now_ms    = $urandom;
        end
        return it;
    endfunction

    task run_random(int count);
        for (int n = 0; n < count; n++)
            send_item(random_item());
        in_valid <= 1'b0;
    endtask

    // Corner items under the reset register values: a check of the empty
    // table, ignored packets and pairs, duplicate IDs where the lowest slot
    // wins, field extremes, the alarm and warning edges, a wrapping age, an
    // age exactly at the timeout, stale and timed-out expiry, and unpairing.
    task run_directed();
        send_item(make_item(MODE_CHECK, 32'd0, 3'd0, 12'd0, 12'd0, 32'd0, 1'b0));
        send_item(make_item(MODE_PACKET, 32'd0, 3'd0, 12'd4095, 12'd0, 32'd0, 1'b0));
        send_item(make_item(MODE_PACKET, 32'd5, 3'd0, 12'd100, 12'd100, 32'd0, 1'b0));
        send_item(make_item(MODE_PAIR, 32'hFFFF_FFFF, 3'd0, 12'd0, 12'd0, 32'd0, 1'b0));
        send_item(make_item(MODE_PAIR, 32'd1, 3'd5, 12'd0, 12'd0, 32'd0, 1'b0));
        send_item(make_item(MODE_PAIR, 32'd7, 3'd6, 12'd0, 12'd0, 32'd0, 1'b0));
        send_item(make_item(MODE_PAIR, 32'd7, 3'd7, 12'd0, 12'd0, 32'd0, 1'b0));
        send_item(make_item(MODE_PAIR, 32'hA5A5_5A5A, 3'd2, 12'd0, 12'd0, 32'd0, 1'b0));
        send_item(make_item(MODE_PAIR, 32'hA5A5_5A5A, 3'd3, 12'd0, 12'd0, 32'd0, 1'b0));
        send_item(make_item(MODE_PACKET, 32'hFFFF_FFFF, 3'd7, 12'd4095, 12'd2047,
                            32'hFFFF_FFF0, 1'b1));
        send_item(make_item(MODE_PACKET, 32'd1, 3'd0, 12'd0, 12'h800, 32'd100, 1'b0));
        send_item(make_item(MODE_PACKET, 32'hA5A5_5A5A, 3'd0, 12'd1120, 12'd1120,
                            32'd200, 1'b0));
        send_item(make_item(MODE_CHECK, 32'd0, 3'd0, 12'd0, 12'd0, 32'd1000, 1'b0));
        send_item(make_item(MODE_PACKET, 32'hA5A5_5A5A, 3'd0, 12'd1200, 12'd1040,
                            32'd300, 1'b0));
        send_item(make_item(MODE_PACKET, 32'd1, 3'd0, 12'd1700, 12'd528, 32'd10, 1'b0));
        send_item(make_item(MODE_CHECK, 32'd0, 3'd0, 12'd0, 12'd0, 32'd600010, 1'b1));
        send_item(make_item(MODE_RADIO, 32'd0, 3'd0, 12'd0, 12'd0, 32'd0, 1'b0));
        send_item(make_item(MODE_CHECK, 32'd0, 3'd0, 12'd0, 12'd0, 32'd600011, 1'b0));
        send_item(make_item(MODE_PACKET, 32'd1, 3'd0, 12'd1121, 12'd527, 32'd700000, 1'b0));
        send_item(make_item(MODE_CHECK, 32'd0, 3'd0, 12'd0, 12'd0, 32'd1300001, 1'b1));
        send_item(make_item(MODE_PAIR, 32'd0, 3'd5, 12'd0, 12'd0, 32'd0, 1'b0));
        send_item(make_item(MODE_PACKET, 32'hA5A5_5A5A, 3'd0, 12'd1760, 12'd1,
                            32'd5, 1'b0));
        send_item(make_item(MODE_PAIR, 32'h5A5A_A5A5, 3'd4, 12'd0, 12'd0, 32'd0, 1'b0));
        send_item(make_item(MODE_CHECK, 32'd0, 3'd0, 12'd0, 12'd0, 32'd0, 1'b0));
        in_valid <= 1'b0;
    endtask

    // The watchdog: a run that is still going at the limit has hung.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        refresh_pool();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_mode = IDLE_NONE;
        run_directed();
        drain();

        // Nominal limits with a short timeout so that readings expire often,
        // and a radio step that moves stamps back; no idling on either side.
        configure(12'd1120, 12'd1760, 12'd1120, 32'd1000, 32'd500);
        refresh_pool();
        run_random(ITEMS_PER_PHASE);
        drain();

        // Lowest pressure minimum and temperature limit, highest pressure maximum and a
        // zero timeout: every fresh slot expires on the next check that moves time on. The sender idles.
        idle_mode = IDLE_SOURCE;
        configure(12'd0, 12'd4095, 12'h800, 32'd0, 32'd0);
        refresh_pool();
        run_random(ITEMS_PER_PHASE);
        drain();

        // Highest pressure minimum and temperature limit, lowest pressure maximum, and the largest
        // timeout and radio step; the receiver stalls and once holds off for a long stretch while items pile up.
        idle_mode = IDLE_SINK;
        configure(12'd4095, 12'd0, 12'd2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        refresh_pool();
        hold_asks = hold_asks + 1;
        run_random(ITEMS_PER_PHASE);
        drain();

        // Random plausible limits; both sides idle now and then.
        idle_mode = IDLE_BOTH;
        configure(12'($urandom_range(800, 1400)), 12'($urandom_range(1500, 2200)),
                  12'($urandom_range(300, 1500)), $urandom_range(200, 3000),
                  $urandom_range(0, 5000));
        refresh_pool();
        run_random(ITEMS_PER_PHASE);
        drain();

        $display("summary: %0d items transferred, %0d slot readings checked, %0d mismatches",
                 sb.items_seen, sb.readings_seen, sb.mismatches);
        $display("summary: corner items, four register settings with both extremes, %s",
                 "idle and stall patterns and a long output hold-off");
        if (sb.mismatches == 0 && sb.due_readings.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
